[sv/cgc_pkg.sv]
`timescale 1ns / 1ps

package cgc_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Width of the threshold field as written on the configuration port.
  localparam int THR_FIELD_W   = 15;
  // Width of the ratio field as written on the configuration port.
  localparam int RATIO_FIELD_W = 14;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes on the configuration port.
  localparam cfg_idx_t REG_THRESHOLD = 2'd0;
  localparam cfg_idx_t REG_RATIO     = 2'd1;
  localparam cfg_idx_t REG_KNEE_MODE = 2'd2;

  // Knee selection.
  typedef enum logic [1:0] {
    KNEE_HARD   = 2'd0,
    KNEE_MEDIUM = 2'd1,
    KNEE_SOFT   = 2'd2
  } knee_mode_t;

endpackage

[sv/cgc_div.sv]
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per register stage.
// The caller guarantees num < den * 2^QW, so the quotient fits in QW bits.
module cgc_div #(
  parameter int NW  = 48,
  parameter int DNW = 26,
  parameter int QW  = 22
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic           out_valid,
  output logic [QW-1:0]  quo
);

  logic [DNW-1:0] rem_r [QW];
  logic [DNW-1:0] den_r [QW];
  logic [QW-1:0]  low_r [QW];
  logic [QW-1:0]  q_r   [QW];
  logic           v_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DNW-1:0] rem_in;
    logic [DNW-1:0] den_in;
    logic [QW-1:0]  low_in;
    logic [QW-1:0]  q_in;
    logic           v_in;
    logic [DNW:0]   trial;
    logic [DNW:0]   diff;
    logic           ge;
    logic [DNW-1:0] rem_nxt;
    logic [QW-1:0]  q_nxt;

    // Stage inputs come from the ports for the first stage, else from the stage before.
    if (k == 0) begin : g_first
      assign rem_in = num[NW-1:QW];
      assign den_in = den;
      assign low_in = num[QW-1:0];
      assign q_in   = '0;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign v_in   = v_r[k-1];
    end

    // Bring down the next numerator bit and try a subtraction.
    always_comb begin
      trial   = {rem_in, low_in[QW-1-k]};
      diff    = trial - {1'b0, den_in};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? diff[DNW-1:0] : trial[DNW-1:0];
      q_nxt   = q_in;
      q_nxt[QW-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_in;
      low_r[k] <= low_in;
      q_r[k]   <= q_nxt;
    end
  end

  assign out_valid = v_r[QW-1];
  assign quo       = q_r[QW-1];

endmodule

[sv/compressor_gain_computer.sv]
`timescale 1ns / 1ps

// Gain computer with hard, medium or soft knee for a dynamic range compressor.
// Input channel: present a detected level on in_level_db and raise start; the word is
// taken at a rising edge where start is high and busy is low. Busy is high only in the
// cycle that follows reset, so a new word may be taken on every clock edge after that.
// Result channel: out_valid marks out_gain_reduction_db for exactly one cycle. The
// result is zero or negative, signed with FRAC_BITS fraction bits, and saturates at
// the most negative code. Results leave in the order their words came in.
// A word passes an input register, the compare, multiply and rounding stages, the
// divider, which resolves one quotient bit per stage, and an output register that
// saturates and negates. Throughput is one word per cycle once busy is low.
// Configuration: cfg_valid with cfg_index and cfg_data writes threshold, ratio or knee
// mode; cfg_ready is always high and written values are clamped to their legal range.
// Write configuration only while no word is in flight.
// Reset restores threshold -20 dB, ratio 4 and hard knee, and empties the pipeline.
// The receiver cannot hold results off, so nothing in the block ever stalls.
module compressor_gain_computer
  import cgc_pkg::*;
#(
  parameter int LEVEL_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [LEVEL_WIDTH-1:0] in_level_db,
  output logic                   out_valid,
  output logic [LEVEL_WIDTH-1:0] out_gain_reduction_db,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Fixed-point constants.
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int HARD_HALF = (ONE_Q + 10) / 20;
  localparam int MED_HALF  = 3 << (FRAC_BITS - 1);
  localparam int SOFT_HALF = 3 << FRAC_BITS;
  localparam int THR_MIN   = -(60 << FRAC_BITS);
  localparam int THR_RST   = -(20 << FRAC_BITS);
  localparam int RATIO_MAX = 32 << FRAC_BITS;
  localparam int RATIO_RST = 4 << FRAC_BITS;

  // Widths of stored and internal values.
  localparam int TW   = (FRAC_BITS + 7 > THR_FIELD_W) ? FRAC_BITS + 7 : THR_FIELD_W;
  localparam int RW   = FRAC_BITS + 6;
  localparam int HW   = FRAC_BITS + 2;
  localparam int KW   = FRAC_BITS + 3;
  localparam int B1   = (LEVEL_WIDTH > KW) ? LEVEL_WIDTH : KW;
  localparam int BASE = (B1 > TW) ? B1 : TW;
  localparam int DW   = BASE + 2;
  localparam int XW   = DW - 1;
  localparam int M1W  = RW + XW;
  localparam int DNW  = RW + HW + 2;
  localparam int NW   = DNW + XW;
  localparam int LATENCY = XW + 7;
  localparam logic [XW-1:0] LIMIT = XW'(1) << (LEVEL_WIDTH - 1);

  // Configuration registers.
  logic signed [TW-1:0] thr_r;
  logic [RW-1:0]        ratio_r;
  knee_mode_t           knee_mode_r;
  logic                 busy_r;

  // Pipeline registers.
  logic                          v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [LEVEL_WIDTH-1:0] level0_r;
  logic signed [DW-1:0]          over1_r, d1_r, e1_r;
  logic [XW-1:0]                 x2_r;
  logic [KW-1:0]                 dk2_r, dk3_r;
  logic                          knee2_r, knee3_r;
  logic [M1W-1:0]                m1_3_r;
  logic [DNW-1:0]                den3_r, den4_r, den5_r;
  logic [NW-1:0]                 num4_r, num5_r;
  logic                          out_valid_r;
  logic [LEVEL_WIDTH-1:0]        out_gain_r;

  // Combinational values.
  logic signed [THR_FIELD_W-1:0] thr_field;
  logic [RATIO_FIELD_W-1:0]      ratio_field;
  logic signed [TW-1:0]          thr_nxt;
  logic [RW-1:0]                 ratio_nxt;
  knee_mode_t                    knee_mode_nxt;
  logic [HW-1:0]                 half;
  logic signed [DW-1:0]          lvl_x, thr_x, half_x;
  logic signed [DW-1:0]          over1_nxt, d1_nxt, e1_nxt;
  logic                          knee2_nxt, zero2_nxt;
  logic [XW-1:0]                 x2_nxt;
  logic [RW-1:0]                 slope;
  logic [M1W-1:0]                m1_nxt;
  logic [DNW-1:0]                den3_nxt;
  logic [NW-1:0]                 num4_nxt;
  logic [NW-1:0]                 num5_nxt;
  logic                          div_valid;
  logic [XW-1:0]                 quo;
  logic [XW-1:0]                 red;
  logic [XW-1:0]                 neg;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  // Clamp written configuration values into range.
  always_comb begin
    thr_field   = signed'(cfg_data[THR_FIELD_W-1:0]);
    ratio_field = cfg_data[RATIO_FIELD_W-1:0];
    if (int'(thr_field) < THR_MIN) begin
      thr_nxt = TW'(THR_MIN);
    end else if (thr_field > 0) begin
      thr_nxt = '0;
    end else begin
      thr_nxt = TW'(thr_field);
    end
    if (int'(ratio_field) < ONE_Q) begin
      ratio_nxt = RW'(ONE_Q);
    end else if (int'(ratio_field) > RATIO_MAX) begin
      ratio_nxt = RW'(RATIO_MAX);
    end else begin
      ratio_nxt = RW'(ratio_field);
    end
    if (cfg_data[1:0] > KNEE_SOFT) begin
      knee_mode_nxt = KNEE_SOFT;
    end else begin
      knee_mode_nxt = knee_mode_t'(cfg_data[1:0]);
    end
  end

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= TW'(THR_RST);
      ratio_r     <= RW'(RATIO_RST);
      knee_mode_r <= KNEE_HARD;
      busy_r      <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r       <= thr_nxt;
          REG_RATIO:     ratio_r     <= ratio_nxt;
          REG_KNEE_MODE: knee_mode_r <= knee_mode_nxt;
          default: ;
        endcase
      end
    end
  end

  // Half width of the knee for the current mode.
  always_comb begin
    case (knee_mode_r)
      KNEE_HARD:   half = HW'(HARD_HALF);
      KNEE_MEDIUM: half = HW'(MED_HALF);
      KNEE_SOFT:   half = HW'(SOFT_HALF);
      default:     half = HW'(SOFT_HALF);
    endcase
  end

  // Stage 1: distances of the level from threshold, knee start and knee end.
  always_comb begin
    lvl_x     = DW'(level0_r);
    thr_x     = DW'(thr_r);
    half_x    = signed'(DW'(half));
    over1_nxt = lvl_x - thr_x;
    d1_nxt    = lvl_x - thr_x + half_x;
    e1_nxt    = lvl_x - thr_x - half_x;
  end

  // Stage 2: pick the region and the operand of the slope multiply.
  always_comb begin
    knee2_nxt = (knee_mode_r != KNEE_HARD) && (d1_r > 0) && (e1_r < 0);
    zero2_nxt = (d1_r <= 0) || (!knee2_nxt && (over1_r <= 0));
    if (zero2_nxt) begin
      x2_nxt = '0;
    end else if (knee2_nxt) begin
      x2_nxt = d1_r[XW-1:0];
    end else begin
      x2_nxt = over1_r[XW-1:0];
    end
  end

  // Stage 3: slope product and divisor.
  always_comb begin
    slope  = ratio_r - RW'(ONE_Q);
    m1_nxt = M1W'(slope) * M1W'(x2_r);
    if (knee2_r) begin
      den3_nxt = DNW'(ratio_r) * DNW'({half, 2'b00});
    end else begin
      den3_nxt = DNW'(ratio_r);
    end
  end

  // Stage 4: second factor of the knee in the quadratic region.
  always_comb begin
    if (knee3_r) begin
      num4_nxt = NW'(m1_3_r) * NW'(dk3_r);
    end else begin
      num4_nxt = NW'(m1_3_r);
    end
  end

  // Stage 5: add half the divisor so the division rounds half up.
  assign num5_nxt = num4_r + NW'(den4_r >> 1);

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v0_r <= start && !busy_r;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Payload of the front stages.
  always_ff @(posedge clk) begin
    level0_r <= signed'(in_level_db);
    over1_r  <= over1_nxt;
    d1_r     <= d1_nxt;
    e1_r     <= e1_nxt;
    x2_r     <= x2_nxt;
    dk2_r    <= d1_r[KW-1:0];
    knee2_r  <= knee2_nxt;
    m1_3_r   <= m1_nxt;
    den3_r   <= den3_nxt;
    dk3_r    <= dk2_r;
    knee3_r  <= knee2_r;
    num4_r   <= num4_nxt;
    den4_r   <= den3_r;
    num5_r   <= num5_nxt;
    den5_r   <= den4_r;
  end

  cgc_div #(
    .NW  (NW),
    .DNW (DNW),
    .QW  (XW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .num       (num5_r),
    .den       (den5_r),
    .out_valid (div_valid),
    .quo       (quo)
  );

  // Saturate the reduction and negate it.
  always_comb begin
    red = (quo > LIMIT) ? LIMIT : quo;
    neg = XW'(0) - red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_gain_r <= neg[LEVEL_WIDTH-1:0];
  end

  assign out_valid             = out_valid_r;
  assign out_gain_reduction_db = out_gain_r;

  // Every result is a cut, never a boost.
  a_result_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain_reduction_db[LEVEL_WIDTH-1] || (out_gain_reduction_db == '0)))
    else $error("gain reduction is positive");

  // Each accepted word yields its result after the fixed pipeline latency.
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LATENCY) out_valid)
    else $error("result strobe missing at the expected latency");

  // The stored ratio keeps the divisor nonzero and the slope in range.
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(ratio_r) >= ONE_Q) && (int'(ratio_r) <= RATIO_MAX))
    else $error("stored ratio out of range");

  // The stored threshold never exceeds 0 dB.
  a_threshold_range: assert property (@(posedge clk) disable iff (!rst_n)
    thr_r[TW-1] || (thr_r == '0))
    else $error("stored threshold above 0 dB");

endmodule
